FILE: src/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the UTF-8 byte stream decoder.
// Depends on nothing; used by every module of the decoder.
package utf8d_pkg;

	localparam int CP_W     = 31;
	localparam int STATUS_W = 3;
	localparam int REM_W    = 3;

	// result status codes; markers 1..4 reuse the status value as code point
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LEAD   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_STRAY      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONCONT    = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0]     cp;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

	// everything one byte produces: up to two results plus the next state
	typedef struct packed {
		result_t          r0;
		result_t          r1;
		logic [1:0]       n;
		logic [CP_W-1:0]  partial;
		logic [REM_W-1:0] remain;
	} decode_t;

endpackage

FILE: src/utf8d_decode.sv
// utf8d_decode: combinational decode of one byte against the pending sequence state.
// Depends on utf8d_pkg.
module utf8d_decode (
	input  logic [7:0]                    data_byte,
	input  logic [utf8d_pkg::CP_W-1:0]    partial,
	input  logic [utf8d_pkg::REM_W-1:0]   remain,
	output utf8d_pkg::decode_t            dec
);
	import utf8d_pkg::*;

	typedef struct packed {
		logic                is_seq;
		logic [CP_W-1:0]     cp;
		logic [STATUS_W-1:0] status;
		logic [REM_W-1:0]    remain;
	} lead_t;

	// idle-state handling of a nonzero byte
	function automatic lead_t lead_info(input logic [7:0] b);
		lead_t l;
		l = '0;
		priority if (b[7] == 1'b0) begin
			l.cp = CP_W'(b);
			l.status = ST_OK;
		end else if (b[7:6] == 2'b10) begin
			l.cp = CP_W'(ST_STRAY);
			l.status = ST_STRAY;
		end else if (b[7:1] == 7'h7F) begin
			l.cp = CP_W'(ST_BAD_LEAD);
			l.status = ST_BAD_LEAD;
		end else if (b[5] == 1'b0) begin
			l.is_seq = 1'b1;
			l.cp = {20'b0, b[4:0], 6'b0};
			l.remain = 3'd1;
		end else if (b[4] == 1'b0) begin
			l.is_seq = 1'b1;
			l.cp = {15'b0, b[3:0], 12'b0};
			l.remain = 3'd2;
		end else if (b[3] == 1'b0) begin
			l.is_seq = 1'b1;
			l.cp = {10'b0, b[2:0], 18'b0};
			l.remain = 3'd3;
		end else if (b[2] == 1'b0) begin
			l.is_seq = 1'b1;
			l.cp = {5'b0, b[1:0], 24'b0};
			l.remain = 3'd4;
		end else begin
			l.is_seq = 1'b1;
			l.cp = {b[0], 30'b0};
			l.remain = 3'd5;
		end
		return l;
	endfunction

	lead_t            lead;
	logic [REM_W-1:0] left;
	logic [CP_W-1:0]  merged;
	logic [5:0]       pay;

	assign lead = lead_info(data_byte);
	assign pay  = data_byte[5:0];

	always_comb begin
		unique case (remain)
			3'd0, 3'd1: left = 3'd0;
			3'd2:       left = 3'd1;
			3'd3:       left = 3'd2;
			3'd4:       left = 3'd3;
			3'd5:       left = 3'd4;
			default:    left = 3'd5;
		endcase
	end

	always_comb begin
		unique case (left)
			3'd0:    merged = partial | {25'b0, pay};
			3'd1:    merged = partial | {19'b0, pay, 6'b0};
			3'd2:    merged = partial | {13'b0, pay, 12'b0};
			3'd3:    merged = partial | {7'b0, pay, 18'b0};
			3'd4:    merged = partial | {1'b0, pay, 24'b0};
			default: merged = partial | {pay[0], 30'b0};
		endcase
	end

	always_comb begin
		dec = '0;
		dec.partial = partial;
		dec.remain  = remain;
		if (remain == '0) begin
			if (data_byte != 8'h00) begin
				if (lead.is_seq) begin
					dec.partial = lead.cp;
					dec.remain  = lead.remain;
				end else begin
					dec.r0 = '{cp: lead.cp, status: lead.status, last: 1'b1};
					dec.n  = 2'd1;
				end
			end
		end else if (data_byte == 8'h00) begin
			dec.r0 = '{cp: CP_W'(ST_INCOMPLETE), status: ST_INCOMPLETE, last: 1'b0};
			dec.r1 = '{cp: partial, status: ST_INCOMPLETE, last: 1'b1};
			dec.n  = 2'd2;
			dec.partial = '0;
			dec.remain  = '0;
		end else if (data_byte[7:6] == 2'b10) begin
			dec.remain = left;
			if (left == '0) begin
				dec.r0 = '{cp: merged, status: ST_OK, last: 1'b1};
				dec.n  = 2'd1;
				dec.partial = '0;
			end else begin
				dec.partial = merged;
			end
		end else begin
			// broken sequence: marker, then the byte again as a lead
			dec.r0 = '{cp: CP_W'(ST_NONCONT), status: ST_NONCONT, last: 1'b1};
			dec.n  = 2'd1;
			dec.partial = '0;
			dec.remain  = '0;
			if (lead.is_seq) begin
				dec.partial = lead.cp;
				dec.remain  = lead.remain;
			end else begin
				dec.r0.last = 1'b0;
				dec.r1 = '{cp: lead.cp, status: lead.status, last: 1'b1};
				dec.n  = 2'd2;
			end
		end
	end

endmodule

FILE: src/utf8d_obuf.sv
// utf8d_obuf: two-slot result queue that drives the output channel.
// Depends on utf8d_pkg.
module utf8d_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  utf8d_pkg::result_t   r0,
	input  utf8d_pkg::result_t   r1,
	input  logic                 out_stall,
	output logic [1:0]           free,
	output logic                 out_valid,
	output utf8d_pkg::result_t   head
);
	import utf8d_pkg::*;

	result_t    slot0_q, slot1_q;
	result_t    nxt0, nxt1;
	logic [1:0] count_q;
	logic [1:0] base;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign head      = slot0_q;
	assign pop       = out_valid && !out_stall;
	assign base      = count_q - {1'b0, pop};
	assign free      = 2'd2 - base;

	always_comb begin
		nxt0 = pop ? slot1_q : slot0_q;
		nxt1 = slot1_q;
		if (push_n != 2'd0) begin
			if (base == 2'd0) begin
				nxt0 = r0;
			end else begin
				nxt1 = r0;
			end
		end
		if (push_n == 2'd2) begin
			nxt1 = r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= base + push_n;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= nxt0;
		slot1_q <= nxt1;
	end

endmodule

FILE: src/utf8_byte_stream_decoder.sv
// A byte is registered into the input stage when taken; its results are then registered
// into the result queue, which drives the outputs.
// Throughput: one byte per cycle while each byte yields at most one result and out_stall
// is low; a byte's two results leave one by one over the single result port.
// Reset (arst_n low, asynchronous): no sequence pending, input stage and result queue empty.
// Depends on utf8d_pkg, utf8d_decode and utf8d_obuf.
module utf8_byte_stream_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	// result request channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [utf8d_pkg::CP_W-1:0]         code_point,
	output logic [utf8d_pkg::STATUS_W-1:0]     status,
	output logic                               last_of_run
);
	import utf8d_pkg::*;

	// input stage: one registered byte request
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// sequence state: gathered code point bits and continuation bytes still expected
	logic [CP_W-1:0]  partial_q;
	logic [REM_W-1:0] remain_q;

	decode_t          dec;
	result_t          head;
	logic [1:0]       free;
	logic [1:0]       push_n;
	logic             fire_s1;
	logic             in_take;

	// decode the staged byte against the current sequence state
	utf8d_decode u_decode (
		.data_byte (byte_s1),
		.partial   (partial_q),
		.remain    (remain_q),
		.dec       (dec)
	);

	// the staged byte retires only when the queue has room for all its results,
	// so a two-result byte never splits across cycles
	assign fire_s1  = valid_s1 && (dec.n <= free);
	assign push_n   = fire_s1 ? dec.n : 2'd0;

	// take a new byte whenever the stage is empty or retiring this cycle
	assign in_stall = valid_s1 && !fire_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			partial_q <= '0;
			remain_q  <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			// state advances once per retired byte
			if (fire_s1) begin
				partial_q <= dec.partial;
				remain_q  <= dec.remain;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
	end

	// result queue: decouples output stalls from the byte stage
	utf8d_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.r0        (dec.r0),
		.r1        (dec.r1),
		.out_stall (out_stall),
		.free      (free),
		.out_valid (out_valid),
		.head      (head)
	);

	assign code_point  = head.cp;
	assign status      = head.status;
	assign last_of_run = head.last;

endmodule

FILE: src/utf8d_checker.sv
// utf8d_checker: port-level checks on the decoder's result stream, bound to the top level.
// Depends on utf8d_pkg and utf8_byte_stream_decoder.
module utf8d_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [utf8d_pkg::CP_W-1:0]         code_point,
	input  logic [utf8d_pkg::STATUS_W-1:0]     status,
	input  logic                               last_of_run
);
	import utf8d_pkg::*;

	// fixed markers carry their status as the code point
	a_marker_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_LEAD || status == ST_STRAY || status == ST_NONCONT)
		|-> code_point == CP_W'(status))
		else $error("marker code point does not match status");

	// decoded, bad-lead and stray results always close their byte's run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK || status == ST_BAD_LEAD || status == ST_STRAY)
		|-> last_of_run)
		else $error("single result not marked last of run");

	// incomplete marker is immediately followed by the partial value
	a_incomplete_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && status == ST_INCOMPLETE && !last_of_run
		|=> out_valid && status == ST_INCOMPLETE && last_of_run)
		else $error("incomplete marker not followed by partial value");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall
		|=> out_valid && $stable(code_point) && $stable(status) && $stable(last_of_run))
		else $error("stalled result changed");

endmodule

bind utf8_byte_stream_decoder utf8d_checker u_utf8d_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.code_point  (code_point),
	.status      (status),
	.last_of_run (last_of_run)
);
